@@ rtl/core/csmp_pkg.sv @@
// Shared types and codes for the byte stack with multi-pop.
package csmp_pkg;

    // Operation codes carried in the op field.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_MULTI = 2'd2;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One entry of the per-value occurrence table for each byte value.
    localparam int VALUES  = 256;
    localparam int DIST_W  = 9;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] push_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] removed_byte;
        logic [1:0] status;
        logic [6:0] entry_count;
        logic [6:0] top_repeats;
        logic [6:0] distinct_count;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic clr_step;
        logic set_empty;
        logic set_full;
        logic push_wr;
        logic push_upd;
        logic top_rd;
        logic cnt_rd_top;
        logic cnt_dec;
        logic cnt_zero;
        logic cmp_step;
        logic cmp_done;
        logic nt_rd;
        logic nt_cnt;
        logic nt_rep;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       clr_last;
        logic       fill_zero;
        logic       fill_full;
        logic [1:0] op;
        logic       cmp_busy;
        logic       out_free;
    } sts_t;

endpackage

@@ rtl/core/csmp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module csmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/csmp_datapath.sv @@
// Datapath of the byte stack: stack store, occurrence table, counters and result register.
module csmp_datapath #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  csmp_pkg::in_t  s_data,
    input  csmp_pkg::cmd_t cmd,
    output csmp_pkg::sts_t sts,
    input  logic          m_ready,
    output logic          m_valid,
    output csmp_pkg::out_t m_data
);

    import csmp_pkg::*;

    // Registers and their next values.
    logic [1:0]        op_reg, op_next;
    logic [7:0]        byte_reg, byte_next;
    logic [7:0]        top_reg, top_next;
    logic [7:0]        removed_reg, removed_next;
    logic [1:0]        status_reg, status_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [DIST_W-1:0] distinct_reg, distinct_next;
    logic [CW-1:0]     rep_reg, rep_next;
    logic [CW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     wr_reg, wr_next;
    logic              pend_reg, pend_next;
    logic [7:0]        clr_addr_reg, clr_addr_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    // Memory ports.
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [7:0]    st_wdata, st_rdata;
    logic          ct_we;
    logic [7:0]    ct_waddr, ct_raddr;
    logic [CW-1:0] ct_wdata, ct_rdata;

    // Derived addresses and widened counts for the result fields.
    logic [CW-1:0]   fill_m1;
    logic [AW-1:0]   fill_addr, fill_m1_addr, rd_addr, wr_addr;
    logic [CW+6:0]   fill_ext, rep_ext;

    assign fill_m1      = fill_reg - CW'(1);
    assign fill_addr    = fill_reg[AW-1:0];
    assign fill_m1_addr = fill_m1[AW-1:0];
    assign rd_addr      = rd_reg[AW-1:0];
    assign wr_addr      = wr_reg[AW-1:0];
    assign fill_ext     = {7'b0, fill_reg};
    assign rep_ext      = {7'b0, rep_reg};

    // Stack entries, bottom at address zero.
    csmp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Number of stack entries holding each byte value.
    csmp_ram #(.WIDTH(CW), .DEPTH(VALUES)) u_count (
        .aclk  (aclk),
        .we    (ct_we),
        .waddr (ct_waddr),
        .wdata (ct_wdata),
        .raddr (ct_raddr),
        .rdata (ct_rdata)
    );

    // Command decoding and next-value logic.
    always_comb begin
        op_next       = op_reg;
        byte_next     = byte_reg;
        top_next      = top_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        fill_next     = fill_reg;
        distinct_next = distinct_reg;
        rep_next      = rep_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        pend_next     = pend_reg;
        clr_addr_next = clr_addr_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        st_we    = 1'b0;
        st_waddr = fill_addr;
        st_wdata = byte_reg;
        st_raddr = fill_m1_addr;
        ct_we    = 1'b0;
        ct_waddr = byte_reg;
        ct_wdata = '0;
        ct_raddr = byte_reg;

        if (cmd.latch_in) begin
            op_next      = s_data.op;
            byte_next    = s_data.push_byte;
            removed_next = 8'd0;
            status_next  = ST_OK;
        end

        // Clearing pass over the occurrence table after reset.
        if (cmd.clr_step) begin
            ct_we         = 1'b1;
            ct_waddr      = clr_addr_reg;
            ct_wdata      = '0;
            clr_addr_next = clr_addr_reg + 8'd1;
        end

        if (cmd.set_empty) begin
            status_next = ST_EMPTY;
        end
        if (cmd.set_full) begin
            status_next = ST_FULL;
        end

        // Push: store the byte, then bump its occurrence count.
        if (cmd.push_wr) begin
            st_we    = 1'b1;
            ct_raddr = byte_reg;
        end
        if (cmd.push_upd) begin
            ct_we     = 1'b1;
            ct_waddr  = byte_reg;
            ct_wdata  = ct_rdata + CW'(1);
            rep_next  = ct_rdata + CW'(1);
            fill_next = fill_reg + CW'(1);
            if (ct_rdata == '0) begin
                distinct_next = distinct_reg + DIST_W'(1);
            end
        end

        // Pop: fetch the top byte and its count.
        if (cmd.top_rd) begin
            st_raddr = fill_m1_addr;
        end
        if (cmd.cnt_rd_top) begin
            top_next     = st_rdata;
            removed_next = st_rdata;
            ct_raddr     = st_rdata;
        end
        if (cmd.cnt_dec) begin
            ct_we     = 1'b1;
            ct_waddr  = top_reg;
            ct_wdata  = ct_rdata - CW'(1);
            fill_next = fill_m1;
            if (ct_rdata == CW'(1)) begin
                distinct_next = distinct_reg - DIST_W'(1);
            end
        end

        // Multi-pop: the value disappears entirely, then the store is compacted.
        if (cmd.cnt_zero) begin
            ct_we         = 1'b1;
            ct_waddr      = top_reg;
            ct_wdata      = '0;
            fill_next     = fill_m1;
            distinct_next = distinct_reg - DIST_W'(1);
            rd_next       = '0;
            wr_next       = '0;
            pend_next     = 1'b0;
        end
        if (cmd.cmp_step) begin
            if (rd_reg != fill_reg) begin
                st_raddr  = rd_addr;
                rd_next   = rd_reg + CW'(1);
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
            if (pend_reg && (st_rdata != top_reg)) begin
                st_we    = 1'b1;
                st_waddr = wr_addr;
                st_wdata = st_rdata;
                wr_next  = wr_reg + CW'(1);
            end
        end
        if (cmd.cmp_done) begin
            fill_next = wr_reg;
        end

        // Look up the occurrence count of the new top byte.
        if (cmd.nt_rd) begin
            st_raddr = fill_m1_addr;
            if (fill_reg == '0) begin
                rep_next = '0;
            end
        end
        if (cmd.nt_cnt) begin
            ct_raddr = st_rdata;
        end
        if (cmd.nt_rep) begin
            rep_next = ct_rdata;
        end

        // Result register: loaded when free, released on the output transaction.
        if (cmd.load_out) begin
            m_valid_next               = 1'b1;
            m_data_next.removed_byte   = removed_reg;
            m_data_next.status         = status_reg;
            m_data_next.entry_count    = fill_ext[6:0];
            m_data_next.top_repeats    = rep_ext[6:0];
            m_data_next.distinct_count = distinct_reg[6:0];
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            distinct_reg <= '0;
            rep_reg      <= '0;
            pend_reg     <= 1'b0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            distinct_reg <= distinct_next;
            rep_reg      <= rep_next;
            pend_reg     <= pend_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        byte_reg    <= byte_next;
        top_reg     <= top_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        rd_reg      <= rd_next;
        wr_reg      <= wr_next;
        m_data_reg  <= m_data_next;
    end

    // Status towards the controller.
    assign sts.clr_last  = (clr_addr_reg == 8'hFF);
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.fill_full = (fill_reg == CW'(DEPTH));
    assign sts.op        = op_reg;
    assign sts.cmp_busy  = (rd_reg != fill_reg) || pend_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The entry count never goes beyond the store depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= DEPTH)
        else $error("fill level beyond depth");

    // There cannot be more distinct values than entries.
    a_distinct_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(distinct_reg) <= int'(fill_reg))
        else $error("distinct count exceeds entry count");

    // During compaction the write pointer stays behind the read pointer.
    a_cmp_order: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (wr_reg < rd_reg))
        else $error("compaction write overtook read");

endmodule

@@ rtl/core/csmp_ctrl.sv @@
// Controller state machine sequencing each stack operation.
module csmp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  csmp_pkg::sts_t  sts,
    output csmp_pkg::cmd_t  cmd
);

    import csmp_pkg::*;

    typedef enum logic [3:0] {
        CLEAR,
        IDLE,
        DECODE,
        PUSH_UPD,
        CNT_RD,
        CNT_UPD,
        COMPACT,
        NT_RD,
        NT_CNT,
        NT_REP,
        RESULT
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = DECODE;
                end
            end
            DECODE: begin
                case (sts.op)
                    OP_PUSH: begin
                        if (sts.fill_full) begin
                            cmd.set_full = 1'b1;
                            state_next   = RESULT;
                        end else begin
                            cmd.push_wr = 1'b1;
                            state_next  = PUSH_UPD;
                        end
                    end
                    OP_POP, OP_MULTI: begin
                        if (sts.fill_zero) begin
                            cmd.set_empty = 1'b1;
                            state_next    = RESULT;
                        end else begin
                            cmd.top_rd = 1'b1;
                            state_next = CNT_RD;
                        end
                    end
                    default: begin
                        state_next = RESULT;
                    end
                endcase
            end
            PUSH_UPD: begin
                cmd.push_upd = 1'b1;
                state_next   = RESULT;
            end
            CNT_RD: begin
                cmd.cnt_rd_top = 1'b1;
                state_next     = CNT_UPD;
            end
            CNT_UPD: begin
                if (sts.op == OP_MULTI) begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = COMPACT;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = NT_RD;
                end
            end
            COMPACT: begin
                if (sts.cmp_busy) begin
                    cmd.cmp_step = 1'b1;
                end else begin
                    cmd.cmp_done = 1'b1;
                    state_next   = NT_RD;
                end
            end
            NT_RD: begin
                cmd.nt_rd  = 1'b1;
                state_next = sts.fill_zero ? RESULT : NT_CNT;
            end
            NT_CNT: begin
                cmd.nt_cnt = 1'b1;
                state_next = NT_REP;
            end
            NT_REP: begin
                cmd.nt_rep = 1'b1;
                state_next = RESULT;
            end
            RESULT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == IDLE);

    // A result is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending one");

    // An accepted transaction is always decoded in the following cycle.
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == DECODE))
        else $error("accepted transaction not decoded");

    // Compaction only begins after the top entry has been removed by a multi-pop.
    a_compact_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == COMPACT) |-> ($past(state_reg) == CNT_UPD))
        else $error("compaction entered out of sequence");

endmodule

@@ rtl/core/char_stack_with_multi_pop_unit.sv @@
// Top level of the byte stack with push, pop and multi-pop.
//
// Input transactions (s_valid/s_ready, s_data) carry an operation and a byte:
// push, pop, or multi-pop, which pops the top byte and then deletes every
// other copy of it while the remaining entries keep their order. Each input
// transaction produces exactly one result transaction (m_valid/m_ready,
// m_data) with the removed byte, a status, the new entry count, the number of
// entries equal to the new top and the number of distinct byte values held.
// Items are handled one at a time. Push stores the byte and updates its count;
// pop reads the top byte and decrements its count, and multi-pop clears that
// count and then compacts the entries left below the popped byte, walking
// them through the single read port of the stack store. Both then look up the
// count of the new top unless the stack is left empty. Empty pops, full
// pushes and the unused code go straight to the result. The next transaction
// is accepted in the cycle after the result is loaded.
// After reset the per-value occurrence table is cleared in a pass over all
// 256 entries, during which s_ready stays low. A stalled receiver holds the
// result in the output register; the block accepts the next transaction
// meanwhile and waits only when its own result is ready to be loaded.
module char_stack_with_multi_pop_unit #(
    parameter int DEPTH = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  csmp_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output csmp_pkg::out_t  m_data
);

    import csmp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Operation sequencer.
    csmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage, counters and result register.
    csmp_datapath #(.DEPTH(DEPTH)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

@@ tb/sv/char_stack_with_multi_pop_unit_tb.sv @@
// Self-checking testbench for the byte stack with push, pop and multi-pop.
`timescale 1ns / 100ps

module char_stack_with_multi_pop_unit_tb;
    import csmp_pkg::*;

    localparam int DEPTH         = 64;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS   = 330;
    localparam int PRINT_LIMIT   = 100;

    // The fourth opcode is unused and must leave the stack untouched.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Mirrors the stack contents and queues the reply each transaction should produce.
    class byte_stack_tracker #(int CAP = 64);
        logic [7:0] entries [CAP];
        int         level = 0;
        out_t       awaited [$];
        int         mismatch_count = 0;

        function int occurrences(logic [7:0] value);
            int n;
            n = 0;
            for (int i = 0; i < level; i++) begin
                if (entries[i] == value) n++;
            end
            return n;
        endfunction

        function int distinct_values();
            logic [255:0] seen;
            int           n;
            seen = '0;
            n = 0;
            for (int i = 0; i < level; i++) begin
                if (!seen[entries[i]]) begin
                    seen[entries[i]] = 1'b1;
                    n++;
                end
            end
            return n;
        endfunction

        // Applies one accepted operation to the mirror and records the reply it implies.
        function void apply_op(in_t item);
            out_t       reply;
            logic [7:0] top_byte;
            int         kept;
            reply = '0;
            reply.status = ST_OK;
            case (item.op)
                OP_PUSH: begin
                    if (level >= CAP) begin
                        reply.status = ST_FULL;
                    end else begin
                        entries[level] = item.push_byte;
                        level++;
                    end
                end
                OP_POP, OP_MULTI: begin
                    if (level == 0) begin
                        reply.status = ST_EMPTY;
                    end else begin
                        top_byte = entries[level-1];
                        level--;
                        reply.removed_byte = top_byte;
                        // Multi-pop squeezes out every other copy of the popped byte.
                        if (item.op == OP_MULTI) begin
                            kept = 0;
                            for (int i = 0; i < level; i++) begin
                                if (entries[i] != top_byte) begin
                                    entries[kept] = entries[i];
                                    kept++;
                                end
                            end
                            level = kept;
                        end
                    end
                end
                default: begin
                end
            endcase
            reply.entry_count    = 7'(level);
            reply.top_repeats    = 7'((level == 0) ? 0 : occurrences(entries[level-1]));
            reply.distinct_count = 7'(distinct_values());
            awaited.push_back(reply);
        endfunction

        task report_mismatch(string what);
            if (mismatch_count < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, what);
            mismatch_count++;
        endtask

        // Compares a result transaction against the oldest queued reply.
        task compare_reply(out_t got);
            out_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result %h arrived with none outstanding", got));
                return;
            end
            want = awaited.pop_front();
            if (got.removed_byte !== want.removed_byte)
                report_mismatch($sformatf("removed_byte %h, wanted %h",
                                          got.removed_byte, want.removed_byte));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count %0d, wanted %0d",
                                          got.entry_count, want.entry_count));
            if (got.top_repeats !== want.top_repeats)
                report_mismatch($sformatf("top_repeats %0d, wanted %0d",
                                          got.top_repeats, want.top_repeats));
            if (got.distinct_count !== want.distinct_count)
                report_mismatch($sformatf("distinct_count %0d, wanted %0d",
                                          got.distinct_count, want.distinct_count));
        endtask

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    byte_stack_tracker #(DEPTH) tracker;

    char_stack_with_multi_pop_unit #(
        .DEPTH(DEPTH)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Free-running clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side: check each completed transaction and vary the ready signal.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.compare_reply(m_data);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on stretches with no transaction on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Presents one operation, optionally after idle cycles, and holds it until accepted.
    task send_item(in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.apply_op(item);
    endtask

    task send_op(logic [1:0] op, logic [7:0] value);
        in_t item;
        item.op        = op;
        item.push_byte = value;
        send_item(item);
    endtask

    // Random operations in runs that fill, drain or hover, with narrow or wide byte values.
    task run_random(int count);
        in_t        item;
        int         run_left;
        int         push_pct;
        int         span;
        logic [7:0] anchor;
        bit         narrow;
        run_left = 0;
        push_pct = 50;
        span     = 1;
        anchor   = '0;
        narrow   = 1'b0;
        repeat (count) begin
            if (run_left == 0) begin
                run_left = $urandom_range(120, 40);
                case ($urandom_range(2))
                    0: push_pct = 90;
                    1: push_pct = 25;
                    default: push_pct = 55;
                endcase
                narrow = 1'($urandom_range(1));
                anchor = 8'($urandom);
                span   = $urandom_range(4, 1);
            end
            run_left--;
            item.push_byte = narrow ? 8'(anchor + $urandom_range(span - 1)) : 8'($urandom);
            if ($urandom_range(99) < 3) begin
                item.op = OP_UNUSED;
            end else if ($urandom_range(99) < push_pct) begin
                item.op = OP_PUSH;
            end else begin
                item.op = $urandom_range(1) ? OP_MULTI : OP_POP;
            end
            send_item(item);
        end
    endtask

    // Main sequence: reset, directed cases, then random traffic under three idling patterns.
    initial begin
        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty stack: both pops report empty, the unused code changes nothing.
        send_op(OP_POP, 8'hFF);
        send_op(OP_MULTI, 8'h00);
        send_op(OP_UNUSED, 8'h00);
        // Extreme bytes, interleaved so that multi-pop has copies to squeeze out.
        send_op(OP_PUSH, 8'h00);
        send_op(OP_PUSH, 8'hFF);
        send_op(OP_PUSH, 8'hFF);
        send_op(OP_PUSH, 8'h00);
        send_op(OP_PUSH, 8'hFF);
        send_op(OP_MULTI, 8'hAA);
        send_op(OP_PUSH, 8'hA5);
        send_op(OP_PUSH, 8'h5A);
        send_op(OP_UNUSED, 8'hFF);
        send_op(OP_POP, 8'h00);
        send_op(OP_POP, 8'h55);
        // Multi-pop that empties the stack entirely, then a pop on empty again.
        send_op(OP_MULTI, 8'h00);
        send_op(OP_POP, 8'h00);
        send_op(OP_PUSH, 8'h7E);
        send_op(OP_PUSH, 8'h81);
        send_op(OP_MULTI, 8'h00);

        send_idle_pct = 34;
        recv_idle_pct = 57;
        run_random(PHASE_ITEMS);
        send_idle_pct = 57;
        recv_idle_pct = 34;
        run_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        s_valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
